### rtl/core/dem_bilinear_sampler_assert.svh
// Assertion macros shared by the checker of the elevation sampler.
// Both expect signals named clock and reset in the scope where they are used.
`ifndef DEM_BILINEAR_SAMPLER_ASSERT_SVH
`define DEM_BILINEAR_SAMPLER_ASSERT_SVH

// Same-cycle implication.
`define DBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/dbs_pkg.sv
// Shared types and constants of the elevation sampler.
// No dependencies; used by the divider, the top level and the checker.
`default_nettype none

package dbs_pkg;

   localparam int ROWS     = 256;
   localparam int COLS     = 256;
   localparam int ROW_BITS = $clog2(ROWS);
   localparam int COL_BITS = $clog2(COLS);
   localparam int ADDR_W   = $clog2(ROWS * COLS);

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 48;
   localparam int DIVD_W    = COORD_W + 1;
   localparam int DIVS_W    = COORD_W;
   localparam int QUOT_W    = DIVD_W + FRAC_BITS;
   localparam int POS_W     = 38;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_NEAREST  = 2'd1;
   localparam logic [1:0] OP_BILINEAR = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BOUNDS = 2'd1;
   localparam logic [1:0] ST_STORE  = 2'd2;

   localparam logic [2:0] CSR_SOUTH   = 3'd0;
   localparam logic [2:0] CSR_NORTH   = 3'd1;
   localparam logic [2:0] CSR_WEST    = 3'd2;
   localparam logic [2:0] CSR_EAST    = 3'd3;
   localparam logic [2:0] CSR_COLSTEP = 3'd4;
   localparam logic [2:0] CSR_ROWSTEP = 3'd5;
   localparam logic [2:0] CSR_MISSING = 3'd6;

   typedef struct packed {
      logic                busy;
      logic                rem_nz;
      logic [QUOT_W-1:0]   quot;
   } div_res_type;

endpackage

`default_nettype wire

### rtl/core/dbs_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dbs_pkg for widths and the result struct.
`default_nettype none

module dbs_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [dbs_pkg::DIVD_W-1:0] dividend,
   input  wire logic [dbs_pkg::DIVS_W-1:0] divisor,
   output dbs_pkg::div_res_type            result
);

   localparam int CNT_W = $clog2(dbs_pkg::QUOT_W);

   logic [dbs_pkg::QUOT_W-1:0] dvd_ff;
   logic [dbs_pkg::QUOT_W-1:0] quo_ff;
   logic [dbs_pkg::DIVS_W-1:0] rem_ff;
   logic [dbs_pkg::DIVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       busy_ff;
   logic [dbs_pkg::DIVS_W:0]   trial;
   logic [dbs_pkg::DIVS_W:0]   diff;
   logic                       fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[dbs_pkg::QUOT_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         dvd_ff  <= {dividend, {dbs_pkg::FRAC_BITS{1'b0}}};
         dvs_ff  <= divisor;
         rem_ff  <= '0;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[dbs_pkg::QUOT_W-2:0], 1'b0};
         rem_ff <= fits ? diff[dbs_pkg::DIVS_W-1:0] : trial[dbs_pkg::DIVS_W-1:0];
         quo_ff <= {quo_ff[dbs_pkg::QUOT_W-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(dbs_pkg::QUOT_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign result.busy   = busy_ff;
   assign result.rem_nz = |rem_ff;
   assign result.quot   = quo_ff;

endmodule

`default_nettype wire

### rtl/core/dem_bilinear_sampler.sv
// Elevation sampler: a tile of 16-bit samples with nearest or bilinear lookup.
// Request channel req_*: opcode 0 writes req_sample at (req_row, req_column);
// opcode 1 and 2 query (req_latitude, req_longitude); opcode 3 is dropped.
// Each query yields one transfer on rsp_*: altitude in 1/256 m and status
// (0 ok, 1 outside bounds, 2 neighbour outside the store or zero step).
// A write gives no result. A query runs a 65-step bit-serial divider for
// the row and column positions in parallel, then reads its neighbours from
// the store one per cycle; a query that fails its checks skips the reads.
// The next request is taken once the sequencer is back in idle; one query
// is in flight at a time.
// req_stall is high while a query is in flight. The result sits in an
// output register; if rsp_stall holds it, the finished query waits in its
// last state and req_stall stays high until the result register frees up.
// Synchronous reset returns the sequencer to idle, drops rsp_valid and
// loads the configuration defaults. The sample store is not cleared;
// entries read before being written return unspecified values.
// Configuration is written through csr_write/csr_index/csr_data; the user
// must write it only while idle, and the block itself does not enforce
// this.
`default_nettype none

module dem_bilinear_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic signed [47:0] req_latitude,
   input  wire logic signed [47:0] req_longitude,
   input  wire logic [7:0]  req_row,
   input  wire logic [7:0]  req_column,
   input  wire logic signed [15:0] req_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [23:0] rsp_altitude,
   output logic [1:0]       rsp_status
);

   localparam int RB  = dbs_pkg::ROW_BITS;
   localparam int CB  = dbs_pkg::COL_BITS;
   localparam int AW  = dbs_pkg::ADDR_W;
   localparam int PW  = dbs_pkg::POS_W;
   localparam int FB  = dbs_pkg::FRAC_BITS;
   localparam int IXW = PW - FB;

   typedef enum logic [2:0] {
      S_IDLE, S_PREP, S_DIV, S_POS, S_CHECK, S_READ, S_FINISH
   } state_type;

   // Configuration registers.
   logic signed [47:0] south_ff, north_ff, west_ff, east_ff;
   logic signed [47:0] col_step_ff, row_step_ff;
   logic signed [15:0] missing_ff;

   state_type state_ff;
   logic                   is_bil_ff;
   logic                   inb_ff;
   logic signed [48:0]     dlat_ff, dlon_ff;
   logic signed [PW-1:0]   pr_ff, pc_ff;
   logic [1:0]             status_ff;
   logic [RB-1:0]          row_ix_ff;
   logic [CB-1:0]          col_ix_ff;
   logic [FB-1:0]          fr_ff, fc_ff;
   logic [2:0]             cnt_ff;
   logic [AW-1:0]          addr_ff;
   logic [2*FB+1:0]        w_ff, w2_ff;
   logic                   iv_ff, rv_ff, pv_ff;
   logic signed [15:0]     rd_ff;
   logic signed [49:0]     prod_ff;
   logic signed [49:0]     acc_ff;
   logic                   rsp_valid_ff;
   logic signed [23:0]     rsp_alt_ff;
   logic [1:0]             rsp_status_ff;

   logic signed [15:0] elev_mem [dbs_pkg::ROWS * dbs_pkg::COLS];

   logic                   accept;
   logic                   is_query;
   logic                   inb_in;
   logic                   mem_we;
   logic [AW-1:0]          mem_wa;
   logic                   div_start;
   logic [dbs_pkg::DIVD_W-1:0] mag_lat, mag_lon;
   logic [dbs_pkg::DIVS_W-1:0] mag_rs, mag_cs;
   dbs_pkg::div_res_type   div_r, div_c;
   logic signed [PW-1:0]   pr_in, pc_in;
   logic signed [PW:0]     tr, tc;
   logic                   fail_r, fail_c, zero_step;
   logic [1:0]             status_in;
   logic [RB-1:0]          row_ix_in;
   logic [CB-1:0]          col_ix_in;
   logic [FB-1:0]          fr_in, fc_in;
   logic [2:0]             n_reads;
   logic [RB-1:0]          row_sel;
   logic [CB-1:0]          col_sel;
   logic [FB:0]            wr_sel, wc_sel;
   logic [AW-1:0]          addr_in;
   logic [2*FB+1:0]        w_in;
   logic signed [49:0]     rounded;
   logic                   rsp_load;

   // Saturated fixed-point position from the divider result.
   function automatic logic signed [PW-1:0] to_pos(
      input dbs_pkg::div_res_type res,
      input logic                 neg
   );
      logic [PW-2:0] mag;
      logic          sat;
      sat = (|res.quot[dbs_pkg::QUOT_W-1:37]) || (res.quot[36] && (|res.quot[35:16]));
      mag = sat ? {1'b1, 20'd0, res.quot[FB-1:0]} : res.quot[PW-2:0];
      if (neg) begin
         to_pos = -$signed({1'b0, mag}) - $signed({{(PW-1){1'b0}}, res.rem_nz});
      end else begin
         to_pos = $signed({1'b0, mag});
      end
   endfunction

   assign accept   = req_valid && !req_stall;
   assign is_query = (req_opcode == dbs_pkg::OP_NEAREST) ||
                     (req_opcode == dbs_pkg::OP_BILINEAR);
   assign inb_in   = (req_latitude >= south_ff) && (req_latitude < north_ff) &&
                     (req_longitude >= west_ff) && (req_longitude < east_ff);
   assign mem_we   = accept && (req_opcode == dbs_pkg::OP_WRITE) &&
                     (32'(req_row) < 32'(dbs_pkg::ROWS)) &&
                     (32'(req_column) < 32'(dbs_pkg::COLS));
   assign mem_wa   = AW'(RB'(req_row)) * AW'(dbs_pkg::COLS) + AW'(CB'(req_column));
   assign div_start = (state_ff == S_PREP);

   // The result register loads when the finished query finds it free or
   // draining in this cycle.
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Magnitudes for the dividers, taken from the registered offsets.
   always_comb begin
      mag_lat = dlat_ff[48] ? dbs_pkg::DIVD_W'(-dlat_ff) : dbs_pkg::DIVD_W'(dlat_ff);
      mag_lon = dlon_ff[48] ? dbs_pkg::DIVD_W'(-dlon_ff) : dbs_pkg::DIVD_W'(dlon_ff);
      mag_rs  = row_step_ff[47] ? dbs_pkg::DIVS_W'(-row_step_ff) : row_step_ff;
      mag_cs  = col_step_ff[47] ? dbs_pkg::DIVS_W'(-col_step_ff) : col_step_ff;
   end

   dbs_divider u_div_row (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_lat),
      .divisor  (mag_rs),
      .result   (div_r)
   );

   dbs_divider u_div_col (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_lon),
      .divisor  (mag_cs),
      .result   (div_c)
   );

   assign pr_in = to_pos(div_r, dlat_ff[48] ^ row_step_ff[47]);
   assign pc_in = to_pos(div_c, dlon_ff[48] ^ col_step_ff[47]);

   // Index and range checks. Nearest rounds half up and reads one sample
   // with full weight; bilinear floors and needs the next row and column.
   always_comb begin
      tr = {pr_ff[PW-1], pr_ff} + (PW+1)'(1 << (FB - 1));
      tc = {pc_ff[PW-1], pc_ff} + (PW+1)'(1 << (FB - 1));
      if (is_bil_ff) begin
         fail_r    = pr_ff[PW-1] || (pr_ff[PW-1:FB] >= IXW'(dbs_pkg::ROWS - 1));
         fail_c    = pc_ff[PW-1] || (pc_ff[PW-1:FB] >= IXW'(dbs_pkg::COLS - 1));
         row_ix_in = pr_ff[FB +: RB];
         col_ix_in = pc_ff[FB +: CB];
         fr_in     = pr_ff[FB-1:0];
         fc_in     = pc_ff[FB-1:0];
         n_reads   = 3'd4;
      end else begin
         fail_r    = tr[PW] || (tr[PW-1:FB] >= IXW'(dbs_pkg::ROWS));
         fail_c    = tc[PW] || (tc[PW-1:FB] >= IXW'(dbs_pkg::COLS));
         row_ix_in = tr[FB +: RB];
         col_ix_in = tc[FB +: CB];
         fr_in     = '0;
         fc_in     = '0;
         n_reads   = 3'd1;
      end
      zero_step = (row_step_ff == '0) || (col_step_ff == '0);
      if (!inb_ff) begin
         status_in = dbs_pkg::ST_BOUNDS;
      end else if (zero_step || fail_r || fail_c) begin
         status_in = dbs_pkg::ST_STORE;
      end else begin
         status_in = dbs_pkg::ST_OK;
      end
   end

   // Neighbour address and weight for the read issued this cycle.
   always_comb begin
      row_sel = row_ix_ff + RB'(cnt_ff[1]);
      col_sel = col_ix_ff + CB'(cnt_ff[0]);
      wr_sel  = cnt_ff[1] ? {1'b0, fr_ff} : (FB+1)'(1 << FB) - {1'b0, fr_ff};
      wc_sel  = cnt_ff[0] ? {1'b0, fc_ff} : (FB+1)'(1 << FB) - {1'b0, fc_ff};
      addr_in = AW'(row_sel) * AW'(dbs_pkg::COLS) + AW'(col_sel);
      w_in    = wr_sel * wc_sel;
      rounded = acc_ff + 50'sd8388608;
   end

   // Sample store: at most one write and one read a cycle, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         elev_mem[mem_wa] <= req_sample;
      end
      rd_ff <= elev_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         south_ff    <= '0;
         north_ff    <= '0;
         west_ff     <= '0;
         east_ff     <= '0;
         col_step_ff <= 48'sd19088743;
         row_step_ff <= -48'sd19088743;
         missing_ff  <= -16'sd32768;
      end else if (csr_write) begin
         case (csr_index)
            dbs_pkg::CSR_SOUTH:   south_ff    <= csr_data;
            dbs_pkg::CSR_NORTH:   north_ff    <= csr_data;
            dbs_pkg::CSR_WEST:    west_ff     <= csr_data;
            dbs_pkg::CSR_EAST:    east_ff     <= csr_data;
            dbs_pkg::CSR_COLSTEP: col_step_ff <= csr_data;
            dbs_pkg::CSR_ROWSTEP: row_step_ff <= csr_data;
            dbs_pkg::CSR_MISSING: missing_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Read, multiply and accumulate pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
         pv_ff <= 1'b0;
      end else begin
         rv_ff <= iv_ff;
         pv_ff <= rv_ff;
      end
      w2_ff   <= w_ff;
      prod_ff <= $signed({1'b0, w2_ff}) * rd_ff;
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         iv_ff        <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         iv_ff <= (state_ff == S_READ) && (cnt_ff < n_reads);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && is_query) begin
                  is_bil_ff <= (req_opcode == dbs_pkg::OP_BILINEAR);
                  inb_ff    <= inb_in;
                  dlat_ff   <= 49'(req_latitude) - 49'(north_ff);
                  dlon_ff   <= 49'(req_longitude) - 49'(west_ff);
                  state_ff  <= S_PREP;
               end
            end
            S_PREP: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!div_r.busy && !div_c.busy) begin
                  state_ff <= S_POS;
               end
            end
            S_POS: begin
               pr_ff    <= pr_in;
               pc_ff    <= pc_in;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               status_ff <= status_in;
               row_ix_ff <= row_ix_in;
               col_ix_ff <= col_ix_in;
               fr_ff     <= fr_in;
               fc_ff     <= fc_in;
               cnt_ff    <= '0;
               acc_ff    <= '0;
               state_ff  <= (status_in == dbs_pkg::ST_OK) ? S_READ : S_FINISH;
            end
            S_READ: begin
               if (cnt_ff < n_reads) begin
                  addr_ff <= addr_in;
                  w_ff    <= w_in;
               end
               if (pv_ff) begin
                  acc_ff <= acc_ff + prod_ff;
               end
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == (is_bil_ff ? 3'd6 : 3'd3)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (rsp_load) begin
                  rsp_status_ff <= status_ff;
                  rsp_alt_ff    <= (status_ff == dbs_pkg::ST_OK) ?
                                   rounded[47:24] : {missing_ff, 8'd0};
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_altitude = rsp_alt_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/core/dbs_checker.sv
// Port-level checker for the elevation sampler, bound to the top level.
// Depends on dbs_pkg and dem_bilinear_sampler_assert.svh.
`default_nettype none
`include "dem_bilinear_sampler_assert.svh"

module dbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_opcode,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [23:0] rsp_altitude,
   input wire logic [1:0]  rsp_status
);

   // A stalled result holds still.
   `DBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_altitude) && $stable(rsp_status), "stalled result changed")

   // Only the three defined status codes leave the block.
   `DBS_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == dbs_pkg::ST_OK) || (rsp_status == dbs_pkg::ST_BOUNDS) || (rsp_status == dbs_pkg::ST_STORE), "undefined status")

   // A failed query reports the nodata code in whole metres.
   `DBS_ASSERT_NOW(a_fail_whole, rsp_valid && (rsp_status != dbs_pkg::ST_OK), rsp_altitude[7:0] == 8'd0, "nodata altitude has a fraction")

   // A query transfer occupies the block on the following cycle.
   `DBS_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && ((req_opcode == dbs_pkg::OP_NEAREST) || (req_opcode == dbs_pkg::OP_BILINEAR)), req_stall, "query did not occupy the block")

endmodule

bind dem_bilinear_sampler dbs_checker u_dbs_checker (.*);

`default_nettype wire
